/* rtl/sst_pkg.sv */
// Shared types and constants of the session slot table.
package sst_pkg;

  localparam int unsigned SeqW  = 32;
  localparam int unsigned FlagW = 6;
  localparam int unsigned CfgW  = 7;
  localparam int unsigned StatW = 4;
  localparam int unsigned GntW  = 6;
  localparam int unsigned EntW  = SeqW + FlagW;

  // flag bit positions
  localparam int unsigned FlFree   = 0;
  localparam int unsigned FlInuse  = 1;
  localparam int unsigned FlError  = 2;
  localparam int unsigned FlRecall = 3;
  localparam int unsigned FlInNew  = 4;
  localparam int unsigned FlInRep  = 5;

  localparam logic [CfgW-1:0] ActiveSlotsRst = 7'd64;

  typedef enum logic [2:0] {
    OP_CHECK    = 3'd0,
    OP_ALLOC    = 3'd1,
    OP_RELEASE  = 3'd2,
    OP_ADD_SEQ  = 3'd3,
    OP_SET_FL   = 3'd4,
    OP_CLR_ERR  = 3'd5,
    OP_RECALL   = 3'd6
  } op_e;

  // opcode with no operation behind it: no effect, status ok
  localparam logic [2:0] OpUnused = 3'd7;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 4'd0,
    ST_REPLAY    = 4'd1,
    ST_NEW       = 4'd2,
    ST_MREPLAY   = 4'd3,
    ST_MNEW      = 4'd4,
    ST_BAD_SLOT  = 4'd5,
    ST_BUSY      = 4'd6,
    ST_NONE_FREE = 4'd7,
    ST_NOT_MARK  = 4'd8
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_e;

  // slot bookkeeping update from the execute stage
  typedef struct packed {
    logic en;         // slot written this cycle
    logic set_valid;  // slot becomes present
    logic free;       // free flag after the write
  } slot_upd_t;

endpackage

/* rtl/sst_ram.sv */
// Generic single-port-write, registered-read RAM.
module sst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sst_alloc.sv */
// Slot presence and free bits with lowest-available-slot search.
module sst_alloc #(
  parameter int unsigned SLOTS = 64,
  parameter int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [31:0]        limit_i,
  input  logic [AW-1:0]      look_idx_i,
  output logic               look_valid_o,
  output logic               hit_o,
  output logic [AW-1:0]      hit_idx_o,
  output logic               hit_valid_o,
  input  logic [AW-1:0]      upd_idx_i,
  input  sst_pkg::slot_upd_t upd_i
);
  import sst_pkg::*;

  logic [SLOTS-1:0] valid_q;
  logic [SLOTS-1:0] free_q;
  logic [SLOTS-1:0] cand;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      free_q  <= '0;
    end else if (upd_i.en) begin
      if (upd_i.set_valid) begin
        valid_q[upd_idx_i] <= 1'b1;
      end
      free_q[upd_idx_i] <= upd_i.free;
    end
  end

  // absent or free, and below the active limit
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      cand[i] = (!valid_q[i] || free_q[i]) && (32'(i) < limit_i);
    end
  end

  always_comb begin
    hit_o     = 1'b0;
    hit_idx_o = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_o     = 1'b1;
        hit_idx_o = AW'(i);
      end
    end
  end

  assign hit_valid_o  = valid_q[hit_idx_o];
  assign look_valid_o = valid_q[look_idx_i];

endmodule

/* rtl/session_slot_table.sv */
// Session slot table: top level with request FSM and slot read-modify-write.
// Flow: the accepting edge starts the memory read; in the EXEC state the entry is
//   updated and written back, and the result register then pulses done_o.
// One item at a time: busy_o is high for the one cycle in which the slot memory
//   read returns and the entry is written back; items are accepted only in IDLE.
// Reset: presence bits cleared, active_slots = 64, done_o low. Slot memory
//   contents are not cleared; an entry is used only after it was written.
module session_slot_table #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [2:0]                 opcode_i,
  input  logic [31:0]                slot_index_i,
  input  logic [sst_pkg::SeqW-1:0]   sequence_req_i,
  input  logic [sst_pkg::SeqW-1:0]   amount_i,
  input  logic [sst_pkg::FlagW-1:0]  flag_bits_i,
  // result
  output logic                       done_o,
  output logic [sst_pkg::StatW-1:0]  status_o,
  output logic [sst_pkg::GntW-1:0]   granted_slot_o,
  output logic [sst_pkg::SeqW-1:0]   slot_sequence_o,
  output logic [sst_pkg::FlagW-1:0]  slot_flags_o,
  // configuration: active_slots
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [sst_pkg::CfgW-1:0]   cfg_data_i
);
  import sst_pkg::*;

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [31:0] SlotsW = 32'(SLOTS);

  // ---------------------------------------------------------------------
  // Configuration: active slot count, clamped to the table depth
  // ---------------------------------------------------------------------
  logic [CfgW-1:0] active_q;
  logic [31:0]     act32;
  logic [31:0]     limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ActiveSlotsRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = !busy_o;
  assign act32       = {{(32 - CfgW){1'b0}}, active_q};
  assign limit       = (act32 < SlotsW) ? act32 : SlotsW;

  // ---------------------------------------------------------------------
  // Control FSM: IDLE accepts, EXEC finishes the read-modify-write.
  // The one-item-at-a-time interlock means a write back always lands
  // before the next read, so no forwarding path is needed.
  // ---------------------------------------------------------------------
  fsm_e state_q, state_d;
  logic accept;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q == S_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Presence / free tracking and the allocate search
  // ---------------------------------------------------------------------
  logic            look_valid;
  logic            hit;
  logic [AW-1:0]   hit_idx;
  logic            hit_valid;
  logic [AW-1:0]   req_idx;
  logic [AW-1:0]   slot_q;
  slot_upd_t       upd;

  assign req_idx = slot_index_i[AW-1:0];

  sst_alloc #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_alloc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limit_i      (limit),
    .look_idx_i   (req_idx),
    .look_valid_o (look_valid),
    .hit_o        (hit),
    .hit_idx_o    (hit_idx),
    .hit_valid_o  (hit_valid),
    .upd_idx_i    (slot_q),
    .upd_i        (upd)
  );

  // ---------------------------------------------------------------------
  // Request capture: the slot number, its presence bit and the range
  // check are settled at accept, together with the memory read address.
  // ---------------------------------------------------------------------
  op_e              op_q;
  logic             known_op_q;
  logic             vld_q;
  logic             in_range_q;
  logic             hit_q;
  logic [SeqW-1:0]  req_q;
  logic [SeqW-1:0]  amt_q;
  logic [FlagW-1:0] fb_q;
  logic             is_alloc;

  assign is_alloc = (opcode_i == OP_ALLOC);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= op_e'(opcode_i);
      known_op_q <= (opcode_i != OpUnused);
      slot_q     <= is_alloc ? hit_idx : req_idx;
      vld_q      <= is_alloc ? hit_valid : look_valid;
      in_range_q <= (slot_index_i < limit);
      hit_q      <= hit;
      req_q      <= sequence_req_i;
      amt_q      <= amount_i;
      fb_q       <= flag_bits_i;
    end
  end

  // ---------------------------------------------------------------------
  // Slot memory: {sequence id, flags}
  // ---------------------------------------------------------------------
  logic [EntW-1:0]  rd_data;
  logic             we;
  logic [SeqW-1:0]  new_seq;
  logic [FlagW-1:0] new_fl;

  sst_ram #(
    .WIDTH (EntW),
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (slot_q),
    .wdata_i ({new_seq, new_fl}),
    .re_i    (accept),
    .raddr_i (is_alloc ? hit_idx : req_idx),
    .rdata_o (rd_data)
  );

  // ---------------------------------------------------------------------
  // Execute: decide the status and the new entry
  // ---------------------------------------------------------------------
  logic [SeqW-1:0]  cur_seq;
  logic [FlagW-1:0] cur_fl;
  logic [SeqW-1:0]  cur_p1;
  logic [SeqW-1:0]  cur_p2;
  status_e          st;
  logic             slot_out;   // result shows the slot number
  logic             ent_out;    // result shows the entry
  logic             set_valid;

  function automatic logic sequence_eq(input logic [SeqW-1:0] a,
                                       input logic [SeqW-1:0] b);
    sequence_eq = (a == b);
  endfunction

  assign cur_seq = rd_data[EntW-1:FlagW];
  assign cur_fl  = rd_data[FlagW-1:0];
  assign cur_p1  = cur_seq + 32'd1;
  assign cur_p2  = cur_seq + 32'd2;

  always_comb begin
    st        = ST_OK;
    new_seq   = cur_seq;
    new_fl    = cur_fl;
    we        = 1'b0;
    set_valid = 1'b0;
    slot_out  = 1'b0;
    ent_out   = 1'b0;
    if (!known_op_q) begin
      st = ST_OK;                      // unused opcode: no effect
    end else if (op_q == OP_ALLOC) begin
      if (!hit_q) begin
        st = ST_NONE_FREE;
      end else begin
        slot_out = 1'b1;
        ent_out  = 1'b1;
        we       = 1'b1;
        new_fl   = '0;
        new_fl[FlInuse] = 1'b1;
        if (!vld_q) begin
          set_valid = 1'b1;
          new_seq   = 32'd1;
        end
      end
    end else if (!in_range_q) begin
      st = ST_BAD_SLOT;
    end else if (op_q == OP_CHECK) begin
      slot_out = 1'b1;
      ent_out  = 1'b1;
      if (!vld_q) begin
        // first use of the slot
        st        = ST_NEW;
        we        = 1'b1;
        set_valid = 1'b1;
        new_seq   = '0;
        new_fl    = '0;
        new_fl[FlInNew] = 1'b1;
      end else if (cur_fl[FlInNew] || cur_fl[FlInRep]) begin
        st = ST_BUSY;
      end else if (sequence_eq(req_q, cur_seq)) begin
        st     = ST_REPLAY;
        we     = 1'b1;
        new_fl = '0;
        new_fl[FlInRep] = 1'b1;
      end else if (sequence_eq(req_q, cur_p1)) begin
        st     = ST_NEW;
        we     = 1'b1;
        new_fl = '0;
        new_fl[FlInNew] = 1'b1;
      end else if (req_q < cur_seq) begin
        st = ST_MREPLAY;
      end else if (req_q >= cur_p2) begin
        st = ST_MNEW;
      end else begin
        st = ST_BAD_SLOT;
      end
    end else if (!vld_q) begin
      slot_out = 1'b1;
      st       = (op_q == OP_RECALL) ? ST_NOT_MARK : ST_BAD_SLOT;
    end else begin
      slot_out = 1'b1;
      ent_out  = 1'b1;
      we       = 1'b1;
      case (op_q)
        OP_RELEASE: begin
          new_fl = '0;
          new_fl[FlFree] = 1'b1;
        end
        OP_ADD_SEQ: new_seq = cur_seq + amt_q;
        OP_SET_FL:  new_fl  = cur_fl | fb_q;
        OP_CLR_ERR: new_fl[FlError] = 1'b0;
        OP_RECALL: begin
          if (cur_fl[FlFree] || cur_fl[FlError] || !sequence_eq(req_q, cur_seq)) begin
            st = ST_NOT_MARK;
            we = 1'b0;
          end else begin
            new_fl[FlRecall] = 1'b1;
          end
        end
        default: we = 1'b0;
      endcase
    end
    if (state_q != S_EXEC) begin
      we        = 1'b0;
      set_valid = 1'b0;
    end
  end

  assign upd.en        = we;
  assign upd.set_valid = set_valid;
  assign upd.free      = new_fl[FlFree];

  // ---------------------------------------------------------------------
  // Result register: one-cycle strobe, receiver cannot stall
  // ---------------------------------------------------------------------
  logic              done_q;
  logic [StatW-1:0]  status_q;
  logic [GntW-1:0]   gnt_q;
  logic [SeqW-1:0]   seq_q;
  logic [FlagW-1:0]  fl_q;
  logic [AW+GntW-1:0] slot_ext;

  assign slot_ext = {{GntW{1'b0}}, slot_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == S_EXEC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      status_q <= st;
      gnt_q    <= slot_out ? slot_ext[GntW-1:0] : '0;
      seq_q    <= ent_out ? new_seq : '0;
      fl_q     <= ent_out ? new_fl : '0;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign granted_slot_o  = gnt_q;
  assign slot_sequence_o = seq_q;
  assign slot_flags_o    = fl_q;

endmodule

/* rtl/session_slot_table_chk.sv */
// Port-level checker for the session slot table, bound to the top level.
module session_slot_table_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic                      done_o,
  input logic [sst_pkg::StatW-1:0] status_o,
  input logic [sst_pkg::GntW-1:0]  granted_slot_o,
  input logic [sst_pkg::SeqW-1:0]  slot_sequence_o,
  input logic [sst_pkg::FlagW-1:0] slot_flags_o
);
  import sst_pkg::*;

  // an accepted item occupies the block for exactly one more cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after accept");

  a_busy_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o && done_o)
    else $error("busy longer than one cycle or result missing");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result without a preceding item");

  a_none_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_NONE_FREE |->
      granted_slot_o == '0 && slot_sequence_o == '0 && slot_flags_o == '0)
    else $error("none_free result carries slot data");

endmodule

bind session_slot_table session_slot_table_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .done_o          (done_o),
  .status_o        (status_o),
  .granted_slot_o  (granted_slot_o),
  .slot_sequence_o (slot_sequence_o),
  .slot_flags_o    (slot_flags_o)
);

/* dv/tb_top.sv */
// Self-checking testbench for the session slot table: directed and random items.
`timescale 1ns / 100ps

module tb_top;
  import sst_pkg::*;

  localparam int unsigned Slots = 64;

  // flag masks built from the package bit positions
  localparam logic [FlagW-1:0] MaskFree   = FlagW'(1 << FlFree);
  localparam logic [FlagW-1:0] MaskInuse  = FlagW'(1 << FlInuse);
  localparam logic [FlagW-1:0] MaskError  = FlagW'(1 << FlError);
  localparam logic [FlagW-1:0] MaskRecall = FlagW'(1 << FlRecall);
  localparam logic [FlagW-1:0] MaskInNew  = FlagW'(1 << FlInNew);
  localparam logic [FlagW-1:0] MaskInRep  = FlagW'(1 << FlInRep);

  // one request item; req_rel asks the driver to aim sequence_req at the
  // slot's current sequence id (plus req_delta) when the item is loaded
  typedef struct {
    logic [2:0]       op;
    logic [31:0]      idx;
    logic [SeqW-1:0]  req;
    logic [SeqW-1:0]  amt;
    logic [FlagW-1:0] fb;
    bit               req_rel;
    int               req_delta;
  } req_item_t;

  // one result item as the block should report it
  typedef struct packed {
    status_e          status;
    logic [GntW-1:0]  gnt;
    logic [SeqW-1:0]  seq;
    logic [FlagW-1:0] fl;
  } slot_result_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  // block inputs, all known from time zero
  logic             start_i        = 1'b0;
  logic [2:0]       opcode_i       = '0;
  logic [31:0]      slot_index_i   = '0;
  logic [SeqW-1:0]  sequence_req_i = '0;
  logic [SeqW-1:0]  amount_i       = '0;
  logic [FlagW-1:0] flag_bits_i    = '0;
  logic             cfg_valid_i    = 1'b0;
  logic [CfgW-1:0]  cfg_data_i     = ActiveSlotsRst;

  // block outputs
  logic             busy_o;
  logic             done_o;
  logic [StatW-1:0] status_o;
  logic [GntW-1:0]  granted_slot_o;
  logic [SeqW-1:0]  slot_sequence_o;
  logic [FlagW-1:0] slot_flags_o;
  logic             cfg_ready_o;

  session_slot_table #(
    .SLOTS(Slots)
  ) u_top (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .opcode_i,
    .slot_index_i,
    .sequence_req_i,
    .amount_i,
    .flag_bits_i,
    .done_o,
    .status_o,
    .granted_slot_o,
    .slot_sequence_o,
    .slot_flags_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i
  );

  // shadow of the slot table and of the active_slots register
  bit               slot_present [Slots];
  logic [SeqW-1:0]  slot_seq     [Slots];
  logic [FlagW-1:0] slot_fl      [Slots];
  logic [CfgW-1:0]  active_cnt = ActiveSlotsRst;

  req_item_t    request_q[$];   // items waiting to be driven
  slot_result_t outcome_q[$];   // results owed by the block, oldest first
  req_item_t    cur_item;       // item on the request ports
  int unsigned  idle_pct  = 0;  // chance in percent that the sender holds off
  int unsigned  fail_cnt  = 0;

  // Predict the result of one accepted item and update the shadow table.
  function automatic slot_result_t apply_request(input req_item_t it);
    slot_result_t res;
    int unsigned  lim;
    logic [5:0]   s;
    logic [SeqW-1:0] cur;
    res = '{ST_OK, '0, '0, '0};
    lim = (active_cnt < Slots) ? active_cnt : Slots;

    // allocate: lowest slot that is absent or marked free
    if (it.op == OP_ALLOC) begin
      res.status = ST_NONE_FREE;
      for (int i = 0; i < lim; i++) begin
        if (!slot_present[i] || slot_fl[i][FlFree]) begin
          if (!slot_present[i]) slot_seq[i] = 32'd1;
          slot_present[i] = 1'b1;
          slot_fl[i] = MaskInuse;
          return '{ST_OK, 6'(i), slot_seq[i], MaskInuse};
        end
      end
      return res;
    end
    if (it.op == OpUnused) return res;

    // out of range: everything zero
    if (it.idx >= lim) begin
      res.status = ST_BAD_SLOT;
      return res;
    end
    s = it.idx[5:0];

    if (it.op == OP_CHECK) begin
      if (!slot_present[s]) begin
        slot_present[s] = 1'b1;
        slot_seq[s] = '0;
        slot_fl[s] = MaskInNew;
        return '{ST_NEW, s, '0, MaskInNew};
      end
      cur = slot_seq[s];
      res.gnt = s;
      res.seq = cur;
      res.fl  = slot_fl[s];
      // compares wrap at 32 bits, in this order
      if ((slot_fl[s] & (MaskInNew | MaskInRep)) != '0) begin
        res.status = ST_BUSY;
      end else if (it.req == cur) begin
        slot_fl[s] = MaskInRep;
        res.status = ST_REPLAY;
        res.fl = MaskInRep;
      end else if (it.req == cur + 32'd1) begin
        slot_fl[s] = MaskInNew;
        res.status = ST_NEW;
        res.fl = MaskInNew;
      end else if (it.req < cur) begin
        res.status = ST_MREPLAY;
      end else if (it.req >= cur + 32'd2) begin
        res.status = ST_MNEW;
      end else begin
        res.status = ST_BAD_SLOT;
      end
      return res;
    end

    // remaining ops on an absent slot only echo the slot number
    if (!slot_present[s]) begin
      res.gnt = s;
      if (it.op == OP_RECALL) res.status = ST_NOT_MARK;
      else res.status = ST_BAD_SLOT;
      return res;
    end

    case (it.op)
      OP_RELEASE: slot_fl[s] = MaskFree;
      OP_ADD_SEQ: slot_seq[s] = slot_seq[s] + it.amt;
      OP_SET_FL:  slot_fl[s] = slot_fl[s] | it.fb;
      OP_CLR_ERR: slot_fl[s] = slot_fl[s] & ~MaskError;
      OP_RECALL: begin
        // refused when free, in error, or the sequence id differs
        if ((slot_fl[s] & (MaskFree | MaskError)) != '0 || slot_seq[s] != it.req)
          res.status = ST_NOT_MARK;
        else
          slot_fl[s] = slot_fl[s] | MaskRecall;
      end
      default: ;
    endcase
    res.gnt = s;
    res.seq = slot_seq[s];
    res.fl  = slot_fl[s];
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // Driver: an item is taken at an edge where start is high and busy low.
  // The prediction is made right there, so the shadow table is exact when
  // the next item is loaded and its relative sequence id is resolved.
  always @(posedge clk_i) begin : drive
    logic      drv_start;
    req_item_t nxt;
    if (rst_ni) begin
      drv_start = start_i;
      if (start_i && !busy_o) begin
        outcome_q.push_back(apply_request(cur_item));
        drv_start = 1'b0;
      end
      if (!drv_start && request_q.size() != 0 &&
          (idle_pct == 0 || $urandom_range(99) >= idle_pct)) begin
        nxt = request_q.pop_front();
        if (nxt.req_rel && nxt.idx < Slots && slot_present[nxt.idx[5:0]])
          nxt.req = slot_seq[nxt.idx[5:0]] + 32'(nxt.req_delta);
        cur_item       = nxt;
        opcode_i       <= nxt.op;
        slot_index_i   <= nxt.idx;
        sequence_req_i <= nxt.req;
        amount_i       <= nxt.amt;
        flag_bits_i    <= nxt.fb;
        drv_start      = 1'b1;
      end
      start_i <= drv_start;
    end
  end

  // Monitor: done_o marks a result for exactly one cycle, no back-pressure.
  always @(posedge clk_i) begin : watch
    slot_result_t exp_r;
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        $error("result with nothing outstanding: status %0d slot %0d",
               status_o, granted_slot_o);
        fail_cnt++;
      end else begin
        exp_r = outcome_q.pop_front();
        check_field("status", exp_r.status, status_o);
        check_field("granted_slot", exp_r.gnt, granted_slot_o);
        check_field("slot_sequence", exp_r.seq, slot_sequence_o);
        check_field("slot_flags", exp_r.fl, slot_flags_o);
      end
    end
  end

  // Block is idle once nothing is queued, driven or owed.
  task automatic wait_idle();
    @(negedge clk_i);
    while (request_q.size() != 0 || start_i || outcome_q.size() != 0)
      @(negedge clk_i);
  endtask

  // active_slots write, only while idle; the shadow follows at the handshake
  task automatic write_active(input logic [CfgW-1:0] val);
    wait_idle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    active_cnt = val;
  endtask

  task automatic push_item(input logic [2:0] op, input logic [31:0] idx,
                           input logic [SeqW-1:0] req, input logic [SeqW-1:0] amt,
                           input logic [FlagW-1:0] fb);
    request_q.push_back('{op, idx, req, amt, fb, 1'b0, 0});
  endtask

  // Random items. Most hit a handful of low slots so that slots go through
  // create / in progress / release / reuse; sequence ids mostly land near
  // the stored one so replay and new requests actually happen.
  task automatic add_random(input int unsigned count);
    req_item_t   it;
    int unsigned lim, hot, r;
    lim = (active_cnt < Slots) ? active_cnt : Slots;
    hot = (lim < 6) ? lim : 6;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 30)      it.op = OP_CHECK;
      else if (r < 40) it.op = OP_ALLOC;
      else if (r < 52) it.op = OP_RELEASE;
      else if (r < 64) it.op = OP_ADD_SEQ;
      else if (r < 74) it.op = OP_SET_FL;
      else if (r < 82) it.op = OP_CLR_ERR;
      else if (r < 97) it.op = OP_RECALL;
      else             it.op = OpUnused;

      r = $urandom_range(99);
      if (r < 70)      it.idx = $urandom_range(hot - 1);
      else if (r < 88) it.idx = $urandom_range(lim - 1);
      else if (r < 94) it.idx = lim + $urandom_range(3);
      else             it.idx = $urandom();

      r = $urandom_range(99);
      it.req_rel   = (r < 75);
      it.req_delta = int'($urandom_range(5)) - 2;
      if (r < 85)      it.req = $urandom_range(3);
      else if (r < 90) it.req = 32'hFFFF_FFFF;
      else             it.req = $urandom();

      r = $urandom_range(99);
      if (r < 60)      it.amt = $urandom_range(3);
      else if (r < 80) it.amt = 32'hFFFF_FFFF - $urandom_range(2);
      else             it.amt = $urandom();

      // single flags half of the time, else any mix
      if ($urandom_range(1)) it.fb = FlagW'(1 << $urandom_range(FlagW - 1));
      else                   it.fb = FlagW'($urandom_range(63));

      request_q.push_back(it);
    end
  endtask

  initial begin : stim
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // one-slot table: the corner cases of a single slot
    write_active(7'd1);
    @(negedge clk_i);
    idle_pct = 24;
    push_item(OP_CHECK,   0, 0, 0, 0);                      // absent -> created
    push_item(OP_CHECK,   0, 0, 0, 0);                      // in progress -> busy
    push_item(OP_CHECK,   32'hFFFF_FFFF, 0, 0, 0);          // out of range
    push_item(OP_ALLOC,   0, 0, 0, 0);                      // nothing free
    push_item(OP_RELEASE, 0, 0, 0, 0);
    push_item(OP_ALLOC,   0, 0, 0, 0);                      // reuse freed slot
    push_item(OP_RECALL,  0, 5, 0, 0);                      // sequence differs
    push_item(OP_RECALL,  0, 0, 0, 0);                      // marked
    push_item(OP_SET_FL,  0, 0, 0, MaskError);
    push_item(OP_RECALL,  0, 0, 0, 0);                      // refused, error set
    push_item(OP_CLR_ERR, 0, 0, 0, 0);
    push_item(OP_ADD_SEQ, 0, 0, 32'hFFFF_FFFF, 0);          // seq wraps to all ones
    push_item(OP_CHECK,   0, 32'hFFFF_FFFF, 0, 0);          // replay
    push_item(OP_RELEASE, 0, 0, 0, 0);
    push_item(OP_RECALL,  0, 32'hFFFF_FFFF, 0, 0);          // refused, slot free
    push_item(OP_CHECK,   0, 0, 0, 0);                      // new across the wrap
    push_item(OP_RELEASE, 0, 0, 0, 0);
    push_item(OP_CHECK,   0, 5, 0, 0);                      // misordered replay
    push_item(OP_ADD_SEQ, 0, 0, 3, 0);
    push_item(OP_CHECK,   0, 10, 0, 0);                     // misordered new
    push_item(OpUnused,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);

    // full table: absent-slot answers and the top boundary
    write_active(7'(Slots));
    @(negedge clk_i);
    push_item(OP_RELEASE, 5, 0, 0, 0);
    push_item(OP_SET_FL,  63, 0, 0, '1);
    push_item(OP_RECALL,  8, 0, 0, 0);
    push_item(OP_CHECK,   Slots, 0, 0, 0);
    push_item(OP_ALLOC,   0, 0, 0, 0);
    push_item(OP_SET_FL,  0, 0, 0, '1);
    add_random(250);

    // sender holds off more often, smaller tables
    write_active(7'd4);
    @(negedge clk_i);
    idle_pct = 56;
    add_random(200);

    write_active(7'($urandom_range(2, Slots - 1)));
    @(negedge clk_i);
    add_random(200);

    // back to back at the largest size
    write_active(7'(Slots));
    @(negedge clk_i);
    idle_pct = 0;
    add_random(250);

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // time limit, far above a correct run
  initial begin : watchdog
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
